// File: rtl/alr_pkg.sv
// Shared constants, command and status types, and blend helpers for the line rasterizer.
`default_nettype none
package alr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int CHAN_BITS   = 8;
  localparam int COLOR_BITS  = 3 * CHAN_BITS;
  localparam int OUTC_BITS   = COORD_BITS + 1;
  localparam int ACC_BITS    = COORD_BITS + FRAC_BITS + 1;
  localparam int SLOPE_BITS  = FRAC_BITS + 2;
  localparam int QUOT_BITS   = FRAC_BITS + 1;
  localparam int REM_BITS    = COORD_BITS + 1;
  localparam int CNT_BITS    = $clog2(QUOT_BITS);

  typedef struct packed {
    logic start_load;
    logic step_load;
    logic div_step;
  } alr_cmd_t;

  typedef struct packed {
    logic zero_len;
    logic div_last;
    logic out_blocked;
  } alr_sts_t;

  function automatic logic [WEIGHT_BITS-1:0] quant_weight(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+WEIGHT_BITS-1:0] t;
    t = {f, {WEIGHT_BITS{1'b0}}};
    return t[FRAC_BITS+WEIGHT_BITS-1:FRAC_BITS];
  endfunction

  function automatic logic [COLOR_BITS-1:0] blend(input logic [COLOR_BITS-1:0] a,
                                                  input logic [COLOR_BITS-1:0] b,
                                                  input logic [WEIGHT_BITS-1:0] w);
    logic [COLOR_BITS-1:0]            res;
    logic [WEIGHT_BITS:0]             wc;
    logic [CHAN_BITS+WEIGHT_BITS:0]   sum;
    logic [CHAN_BITS-1:0]             ca;
    logic [CHAN_BITS-1:0]             cb;
    wc  = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
    wc  = wc - {1'b0, w};
    res = '0;
    for (int c = 0; c < 3; c++) begin
      ca  = a[c*CHAN_BITS +: CHAN_BITS];
      cb  = b[c*CHAN_BITS +: CHAN_BITS];
      sum = (CHAN_BITS+WEIGHT_BITS+1)'(ca) * (CHAN_BITS+WEIGHT_BITS+1)'(w) +
            (CHAN_BITS+WEIGHT_BITS+1)'(cb) * (CHAN_BITS+WEIGHT_BITS+1)'(wc);
      res[c*CHAN_BITS +: CHAN_BITS] = sum[CHAN_BITS+WEIGHT_BITS-1:WEIGHT_BITS];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/alr_ctrl.sv
// Control state machine: input handshake and sequencing of the slope division.
`default_nettype none
module alr_ctrl
  import alr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_mode,
  input  wire alr_sts_t sts,
  output logic          in_stall,
  output alr_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } alr_state_t;

  alr_state_t state_r, state_nxt;
  logic       accept;

  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    state_nxt      = state_r;
    accept         = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall       = sts.out_blocked;
        accept         = in_valid & ~sts.out_blocked;
        cmd.start_load = accept & ~in_mode;
        cmd.step_load  = accept & in_mode;
        if (cmd.start_load && !sts.zero_len) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/alr_dpath.sv
// Datapath: endpoint setup, restoring slope divider, DDA state, pixel blend and output beat.
`default_nettype none
module alr_dpath
  import alr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire alr_cmd_t              cmd,
  output alr_sts_t                   sts,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  input  wire logic [COLOR_BITS-1:0] in_fg_color,
  input  wire logic [COLOR_BITS-1:0] in_bg_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_pixel_valid,
  output logic [OUTC_BITS-1:0]       out_first_x,
  output logic [OUTC_BITS-1:0]       out_first_y,
  output logic [COLOR_BITS-1:0]      out_first_color,
  output logic [OUTC_BITS-1:0]       out_second_x,
  output logic [OUTC_BITS-1:0]       out_second_y,
  output logic [COLOR_BITS-1:0]      out_second_color,
  output logic                       out_line_done
);

  // endpoint setup
  logic signed [COORD_BITS:0] dx, dy, dmin;
  logic [COORD_BITS-1:0]      adx, ady, maj0, maj1, min0, min1, mj0, mj1, mi0, mi1, dmaj;
  logic [COORD_BITS-1:0]      admin;
  logic                       steep;

  always_comb begin
    dx    = $signed({1'b0, in_end_x}) - $signed({1'b0, in_start_x});
    dy    = $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
    adx   = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady   = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    steep = ady > adx;
    mj0   = steep ? in_start_y : in_start_x;
    mj1   = steep ? in_end_y   : in_end_x;
    mi0   = steep ? in_start_x : in_start_y;
    mi1   = steep ? in_end_x   : in_end_y;
    if (mj0 > mj1) begin
      maj0 = mj1; maj1 = mj0; min0 = mi1; min1 = mi0;
    end else begin
      maj0 = mj0; maj1 = mj1; min0 = mi0; min1 = mi1;
    end
    dmaj  = maj1 - maj0;
    dmin  = $signed({1'b0, min1}) - $signed({1'b0, min0});
    admin = dmin[COORD_BITS] ? COORD_BITS'(-dmin) : dmin[COORD_BITS-1:0];
  end

  // divider and line state
  logic [REM_BITS-1:0]          rem_r, rem_nxt;
  logic [QUOT_BITS-1:0]         quot_r, quot_nxt;
  logic [CNT_BITS-1:0]          cnt_r;
  logic [COORD_BITS-1:0]        dmaj_r;
  logic                         neg_r;
  logic                         ge;
  logic [REM_BITS-1:0]          rem_sub;
  logic signed [SLOPE_BITS-1:0] slope_r, slope_nxt;
  logic [ACC_BITS-1:0]          accum_r;
  logic [COORD_BITS-1:0]        major_pos_r, major_end_r, major_inc;
  logic                         steep_r, active_r;
  logic [COLOR_BITS-1:0]        fg_r, bg_r;
  logic                         div_finish;

  always_comb begin
    ge         = rem_r >= {1'b0, dmaj_r};
    rem_sub    = ge ? (rem_r - {1'b0, dmaj_r}) : rem_r;
    rem_nxt    = {rem_sub[REM_BITS-2:0], 1'b0};
    quot_nxt   = {quot_r[QUOT_BITS-2:0], ge};
    slope_nxt  = neg_r ? -$signed({1'b0, quot_nxt}) : $signed({1'b0, quot_nxt});
    div_finish = cmd.div_step & (cnt_r == '0);
  end

  // pixel pair
  logic [ACC_BITS:0]         rnd;
  logic [OUTC_BITS-1:0]      mn, mn2, mpos;
  logic [WEIGHT_BITS-1:0]    w;
  logic [ACC_BITS-1:0]       accum_nxt;

  always_comb begin
    rnd       = {1'b0, accum_r} + ((ACC_BITS+1)'(1) << (FRAC_BITS - 1));
    mn        = rnd[FRAC_BITS +: OUTC_BITS];
    mn2       = mn + OUTC_BITS'(1);
    mpos      = {1'b0, major_pos_r};
    w         = quant_weight(accum_r[FRAC_BITS-1:0]);
    accum_nxt = accum_r + {{(ACC_BITS-SLOPE_BITS){slope_r[SLOPE_BITS-1]}}, slope_r};
    major_inc = major_pos_r + COORD_BITS'(1);
  end

  logic out_valid_r;

  assign sts.zero_len    = (dmaj == '0);
  assign sts.div_last    = (cnt_r == '0);
  assign sts.out_blocked = out_valid_r & out_stall;
  assign out_valid       = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      accum_r     <= '0;
      major_pos_r <= '0;
      major_end_r <= '0;
      slope_r     <= '0;
      steep_r     <= 1'b0;
      fg_r        <= '0;
      bg_r        <= '0;
      cnt_r       <= '0;
    end else begin
      if (cmd.step_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.start_load) begin
        active_r    <= 1'b0;
        fg_r        <= in_fg_color;
        bg_r        <= in_bg_color;
        steep_r     <= steep;
        accum_r     <= {1'b0, min0, {FRAC_BITS{1'b0}}};
        major_pos_r <= maj0;
        major_end_r <= maj1;
        cnt_r       <= CNT_BITS'(QUOT_BITS - 1);
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
      if (div_finish) begin
        slope_r  <= slope_nxt;
        active_r <= 1'b1;
      end
      if (cmd.step_load && active_r) begin
        accum_r     <= accum_nxt;
        major_pos_r <= major_inc;
        if (major_inc == major_end_r) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      rem_r  <= {1'b0, admin};
      dmaj_r <= dmaj;
      neg_r  <= dmin[COORD_BITS];
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
    if (cmd.step_load) begin
      if (active_r) begin
        out_pixel_valid  <= 1'b1;
        out_first_x      <= steep_r ? mn   : mpos;
        out_first_y      <= steep_r ? mpos : mn;
        out_second_x     <= steep_r ? mn2  : mpos;
        out_second_y     <= steep_r ? mpos : mn2;
        out_first_color  <= blend(fg_r, bg_r, w);
        out_second_color <= blend(bg_r, fg_r, w);
        out_line_done    <= (major_inc == major_end_r);
      end else begin
        out_pixel_valid  <= 1'b0;
        out_first_x      <= '0;
        out_first_y      <= '0;
        out_second_x     <= '0;
        out_second_y     <= '0;
        out_first_color  <= '0;
        out_second_color <= '0;
        out_line_done    <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/antialiased_line_raster_unit.sv
// Top level of the antialiased line rasterizer: controller and datapath.
// Step beat: result is in the output register the cycle after acceptance; one step per cycle
// unless input stalls. Start beat: after acceptance, input stalls while the bit-serial
// restoring slope divider runs; a start with coincident endpoints needs no division.
// Input also stalls while a finished result waits and the result side stalls.
// Reset is synchronous, active low: no line active, output register empty.
`default_nettype none
module antialiased_line_raster_unit
  import alr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  input  wire logic [COLOR_BITS-1:0] in_fg_color,
  input  wire logic [COLOR_BITS-1:0] in_bg_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_pixel_valid,
  output logic [OUTC_BITS-1:0]       out_first_x,
  output logic [OUTC_BITS-1:0]       out_first_y,
  output logic [COLOR_BITS-1:0]      out_first_color,
  output logic [OUTC_BITS-1:0]       out_second_x,
  output logic [OUTC_BITS-1:0]       out_second_y,
  output logic [COLOR_BITS-1:0]      out_second_color,
  output logic                       out_line_done
);

  alr_cmd_t cmd;
  alr_sts_t sts;

  alr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  alr_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .in_fg_color      (in_fg_color),
    .in_bg_color      (in_bg_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_valid  (out_pixel_valid),
    .out_first_x      (out_first_x),
    .out_first_y      (out_first_y),
    .out_first_color  (out_first_color),
    .out_second_x     (out_second_x),
    .out_second_y     (out_second_y),
    .out_second_color (out_second_color),
    .out_line_done    (out_line_done)
  );

endmodule
`default_nettype wire

// File: rtl/alr_checker.sv
// Port-level checker for the line rasterizer, bound to the top level.
`default_nettype none
module alr_checker
  import alr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_mode,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_pixel_valid,
  input wire logic [OUTC_BITS-1:0]  out_first_x,
  input wire logic [OUTC_BITS-1:0]  out_first_y,
  input wire logic [COLOR_BITS-1:0] out_first_color,
  input wire logic [OUTC_BITS-1:0]  out_second_x,
  input wire logic [OUTC_BITS-1:0]  out_second_y,
  input wire logic [COLOR_BITS-1:0] out_second_color,
  input wire logic                  out_line_done
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode |=> out_valid)
    else $error("step beat gave no result");

  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_mode && !out_valid |=> !out_valid)
    else $error("start beat gave a result");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> out_line_done && out_first_x == '0 &&
      out_first_y == '0 && out_first_color == '0 && out_second_color == '0)
    else $error("empty result not cleared");

  a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid |->
      (out_first_x == out_second_x) || (out_first_y == out_second_y))
    else $error("pixel pair not on a shared major coordinate");

endmodule

bind antialiased_line_raster_unit alr_checker u_alr_checker (.*);
`default_nettype wire
